@@ hdl/jdq_pkg.sv @@
// Shared widths, codes and types of the joystick direction qualifier.
package jdq_pkg;

  localparam int ADC_BITS   = 12;
  localparam int TIME_W     = 32;
  localparam int MS_W       = 16;
  localparam int STEP_W     = 8;
  localparam int OFS_W      = 12;
  localparam int DIR_W      = 3;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [DIR_W-1:0] DIR_NONE  = 3'd0;
  localparam logic [DIR_W-1:0] DIR_PRESS = 3'd1;
  localparam logic [DIR_W-1:0] DIR_UP    = 3'd2;
  localparam logic [DIR_W-1:0] DIR_DOWN  = 3'd3;
  localparam logic [DIR_W-1:0] DIR_LEFT  = 3'd4;
  localparam logic [DIR_W-1:0] DIR_RIGHT = 3'd5;

  localparam logic [CFG_IDX_W-1:0] REG_CENTER_LOW   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_HIGH  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DEFLECT_LOW  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DEFLECT_HIGH = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_QUIET_MS     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_REPEAT_MS    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET_STEP  = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET_MAX   = 3'd7;

  localparam logic [ADC_BITS-1:0] RST_CENTER_LOW   = 12'd1500;
  localparam logic [ADC_BITS-1:0] RST_CENTER_HIGH  = 12'd2600;
  localparam logic [ADC_BITS-1:0] RST_DEFLECT_LOW  = 12'd1000;
  localparam logic [ADC_BITS-1:0] RST_DEFLECT_HIGH = 12'd3000;
  localparam logic [MS_W-1:0]     RST_QUIET_MS     = 16'd50;
  localparam logic [MS_W-1:0]     RST_REPEAT_MS    = 16'd150;
  localparam logic [STEP_W-1:0]   RST_OFFSET_STEP  = 8'd60;
  localparam logic [OFS_W-1:0]    RST_OFFSET_MAX   = 12'd3000;

  typedef struct packed {
    logic [ADC_BITS-1:0] center_low;
    logic [ADC_BITS-1:0] center_high;
    logic [ADC_BITS-1:0] deflect_low;
    logic [ADC_BITS-1:0] deflect_high;
    logic [MS_W-1:0]     quiet_ms;
    logic [MS_W-1:0]     repeat_ms;
    logic [STEP_W-1:0]   offset_step;
    logic [OFS_W-1:0]    offset_max;
  } cfg_t;

  typedef struct packed {
    logic             sampled;
    logic [DIR_W-1:0] direction;
    logic             action;
    logic             redraw;
    logic             view_mode;
    logic [OFS_W-1:0] view_offset;
  } result_t;

endpackage

@@ hdl/jdq_classify.sv @@
// Direction classifier: button first, then up, down, left and right.
module jdq_classify import jdq_pkg::*; (
  input  cfg_t                cfg,
  input  logic [ADC_BITS-1:0] axis_x,
  input  logic [ADC_BITS-1:0] axis_y,
  input  logic                button_down,
  output logic [DIR_W-1:0]    direction
);

  logic x_centred;
  logic y_centred;

  assign x_centred = (axis_x > cfg.center_low) && (axis_x < cfg.center_high);
  assign y_centred = (axis_y > cfg.center_low) && (axis_y < cfg.center_high);

  always_comb begin
    if (button_down) begin
      direction = DIR_PRESS;
    end else if ((axis_y < cfg.deflect_low) && x_centred) begin
      direction = DIR_UP;
    end else if ((axis_y > cfg.deflect_high) && x_centred) begin
      direction = DIR_DOWN;
    end else if ((axis_x < cfg.deflect_low) && y_centred) begin
      direction = DIR_LEFT;
    end else if ((axis_x > cfg.deflect_high) && y_centred) begin
      direction = DIR_RIGHT;
    end else begin
      direction = DIR_NONE;
    end
  end

endmodule

@@ hdl/jdq_event.sv @@
// Debounce, auto-repeat and view state update for one classified item.
module jdq_event import jdq_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              fire,
  input  logic [TIME_W-1:0] now_ms,
  input  logic [DIR_W-1:0]  direction,
  input  cfg_t              cfg,
  output result_t           res
);

  logic [DIR_W-1:0]  last_dir_r;
  logic [TIME_W-1:0] last_event_r;
  logic              mode_r;
  logic [OFS_W-1:0]  offset_r;

  logic [DIR_W-1:0]  last_dir_nxt;
  logic [TIME_W-1:0] last_event_nxt;
  logic              mode_nxt;
  logic [OFS_W-1:0]  offset_nxt;

  logic [TIME_W-1:0] elapsed;
  logic              pass;
  logic              horiz;
  logic              trig;
  logic              act;
  logic              redraw;
  logic [OFS_W:0]    sum;
  logic [OFS_W-1:0]  left_val;
  logic [OFS_W-1:0]  right_val;
  logic [OFS_W-1:0]  step_ext;

  assign elapsed  = now_ms - last_event_r;
  assign pass     = elapsed >= {{(TIME_W-MS_W){1'b0}}, cfg.quiet_ms};
  assign horiz    = (direction == DIR_LEFT) || (direction == DIR_RIGHT);
  assign trig     = pass && ((direction != last_dir_r) ||
                    (horiz && (elapsed >= {{(TIME_W-MS_W){1'b0}}, cfg.repeat_ms})));
  assign act      = trig && (direction != DIR_NONE);
  assign step_ext = {{(OFS_W-STEP_W){1'b0}}, cfg.offset_step};
  assign sum      = {1'b0, offset_r} + {1'b0, step_ext};
  assign left_val = (sum > {1'b0, cfg.offset_max}) ? cfg.offset_max : sum[OFS_W-1:0];
  assign right_val = (offset_r >= step_ext) ? (offset_r - step_ext) : '0;

  always_comb begin
    last_dir_nxt   = pass ? direction : last_dir_r;
    last_event_nxt = trig ? now_ms : last_event_r;
    mode_nxt       = mode_r;
    offset_nxt     = offset_r;
    redraw         = 1'b0;
    if (act) begin
      if (direction == DIR_UP) begin
        mode_nxt = ~mode_r;
        redraw   = 1'b1;
      end else if ((direction == DIR_LEFT) && !mode_r) begin
        offset_nxt = left_val;
        redraw     = 1'b1;
      end else if ((direction == DIR_RIGHT) && !mode_r) begin
        offset_nxt = right_val;
        redraw     = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_dir_r   <= DIR_NONE;
      last_event_r <= '0;
      mode_r       <= 1'b0;
      offset_r     <= '0;
    end else if (fire) begin
      last_dir_r   <= last_dir_nxt;
      last_event_r <= last_event_nxt;
      mode_r       <= mode_nxt;
      offset_r     <= offset_nxt;
    end
  end

  always_comb begin
    res.sampled     = pass;
    res.direction   = pass ? direction : DIR_NONE;
    res.action      = act;
    res.redraw      = redraw;
    res.view_mode   = mode_nxt;
    res.view_offset = offset_nxt;
  end

endmodule

@@ hdl/joystick_direction_qualifier.sv @@
// Top level of the joystick direction qualifier: channels, registers and item flow.
//
// Each input item is one joystick sample: a millisecond time stamp, the two
// axis readings and the button. Each accepted item yields exactly one result
// item with the debounce verdict, the direction, the action and redraw flags
// and the view mode and offset after that sample.
// An item is accepted at a clock edge where in_valid is high and in_stall is
// low; results move the same way on the out_ channel. The item is captured
// in an input register, classified and applied to the state as it moves on
// into the result register, and presented from the result register on the
// out_ ports, where it can be taken at a clock edge where out_stall is low.
// One item is taken in every cycle while out_stall is low; the single state
// update stage sets that rate.
// When the receiver stalls, the result register holds its item, the input
// register fills, and in_stall rises until the result is taken.
// Configuration registers are written through cfg_valid, cfg_index and
// cfg_data and are always ready; write them only while the block is idle.
// A synchronous reset clears the valid bits of both registers, the direction and
// event time and the view state, and restores the default configuration.
module joystick_direction_qualifier import jdq_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [TIME_W-1:0]     in_now_ms,
  input  logic [ADC_BITS-1:0]   in_axis_x,
  input  logic [ADC_BITS-1:0]   in_axis_y,
  input  logic                  in_button_down,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic                  out_sampled,
  output logic [DIR_W-1:0]      out_direction,
  output logic                  out_action,
  output logic                  out_redraw,
  output logic                  out_view_mode,
  output logic [OFS_W-1:0]      out_view_offset,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  cfg_t                cfg_r;
  logic                s1_valid_r;
  logic [TIME_W-1:0]   s1_now_r;
  logic [ADC_BITS-1:0] s1_x_r;
  logic [ADC_BITS-1:0] s1_y_r;
  logic                s1_btn_r;
  logic                out_valid_r;
  result_t             res_r;

  logic                advance;
  logic                fire;
  logic [DIR_W-1:0]    direction;
  result_t             res;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.center_low   <= RST_CENTER_LOW;
      cfg_r.center_high  <= RST_CENTER_HIGH;
      cfg_r.deflect_low  <= RST_DEFLECT_LOW;
      cfg_r.deflect_high <= RST_DEFLECT_HIGH;
      cfg_r.quiet_ms     <= RST_QUIET_MS;
      cfg_r.repeat_ms    <= RST_REPEAT_MS;
      cfg_r.offset_step  <= RST_OFFSET_STEP;
      cfg_r.offset_max   <= RST_OFFSET_MAX;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_CENTER_LOW:   cfg_r.center_low   <= cfg_data[ADC_BITS-1:0];
        REG_CENTER_HIGH:  cfg_r.center_high  <= cfg_data[ADC_BITS-1:0];
        REG_DEFLECT_LOW:  cfg_r.deflect_low  <= cfg_data[ADC_BITS-1:0];
        REG_DEFLECT_HIGH: cfg_r.deflect_high <= cfg_data[ADC_BITS-1:0];
        REG_QUIET_MS:     cfg_r.quiet_ms     <= cfg_data[MS_W-1:0];
        REG_REPEAT_MS:    cfg_r.repeat_ms    <= cfg_data[MS_W-1:0];
        REG_OFFSET_STEP:  cfg_r.offset_step  <= cfg_data[STEP_W-1:0];
        REG_OFFSET_MAX:   cfg_r.offset_max   <= cfg_data[OFS_W-1:0];
        default: ;
      endcase
    end
  end

  assign advance  = !out_valid_r || !out_stall;
  assign fire     = s1_valid_r && advance;
  assign in_stall = s1_valid_r && !advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (!in_stall) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_now_r <= in_now_ms;
      s1_x_r   <= in_axis_x;
      s1_y_r   <= in_axis_y;
      s1_btn_r <= in_button_down;
    end
  end

  jdq_classify u_classify (
    .cfg         (cfg_r),
    .axis_x      (s1_x_r),
    .axis_y      (s1_y_r),
    .button_down (s1_btn_r),
    .direction   (direction)
  );

  jdq_event u_event (
    .clk       (clk),
    .rst_n     (rst_n),
    .fire      (fire),
    .now_ms    (s1_now_r),
    .direction (direction),
    .cfg       (cfg_r),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      res_r <= res;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_sampled     = res_r.sampled;
  assign out_direction   = res_r.direction;
  assign out_action      = res_r.action;
  assign out_redraw      = res_r.redraw;
  assign out_view_mode   = res_r.view_mode;
  assign out_view_offset = res_r.view_offset;

endmodule

@@ dv/tb.sv @@
// Self-checking testbench for the joystick direction qualifier with its own prediction.
module tb;
  import jdq_pkg::*;

  localparam int AXIS_MAX = (1 << ADC_BITS) - 1;

  typedef enum int {SET_DEFAULT, SET_ZERO, SET_FULL, SET_SANE, SET_WILD} settings_kind_e;
  typedef enum int {ZONE_CENTRE, ZONE_LOW, ZONE_HIGH, ZONE_EDGE, ZONE_ANY} axis_zone_e;

  class direction_tracker;
    cfg_t             regs;
    logic [DIR_W-1:0] last_dir;
    logic [TIME_W-1:0] last_ms;
    logic             mode;
    logic [OFS_W-1:0] offset;
    result_t          pending_results[$];
    int               mismatches;

    function new();
      regs.center_low   = RST_CENTER_LOW;
      regs.center_high  = RST_CENTER_HIGH;
      regs.deflect_low  = RST_DEFLECT_LOW;
      regs.deflect_high = RST_DEFLECT_HIGH;
      regs.quiet_ms     = RST_QUIET_MS;
      regs.repeat_ms    = RST_REPEAT_MS;
      regs.offset_step  = RST_OFFSET_STEP;
      regs.offset_max   = RST_OFFSET_MAX;
      last_dir   = DIR_NONE;
      last_ms    = '0;
      mode       = 1'b0;
      offset     = '0;
      mismatches = 0;
    endfunction

    function void set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_CENTER_LOW:   regs.center_low   = data[ADC_BITS-1:0];
        REG_CENTER_HIGH:  regs.center_high  = data[ADC_BITS-1:0];
        REG_DEFLECT_LOW:  regs.deflect_low  = data[ADC_BITS-1:0];
        REG_DEFLECT_HIGH: regs.deflect_high = data[ADC_BITS-1:0];
        REG_QUIET_MS:     regs.quiet_ms     = data[MS_W-1:0];
        REG_REPEAT_MS:    regs.repeat_ms    = data[MS_W-1:0];
        REG_OFFSET_STEP:  regs.offset_step  = data[STEP_W-1:0];
        REG_OFFSET_MAX:   regs.offset_max   = data[OFS_W-1:0];
        default: ;
      endcase
    endfunction

    function void note_sample(input logic [TIME_W-1:0] now, input logic [ADC_BITS-1:0] x,
                              input logic [ADC_BITS-1:0] y, input logic btn);
      result_t           res;
      logic [TIME_W-1:0] elapsed;
      logic [DIR_W-1:0]  dir;
      logic              xc;
      logic              yc;
      logic              fire;
      logic [OFS_W:0]    sum;
      res     = '0;
      fire    = 1'b0;
      elapsed = now - last_ms;
      if (elapsed >= regs.quiet_ms) begin
        xc = x > regs.center_low && x < regs.center_high;
        yc = y > regs.center_low && y < regs.center_high;
        if (btn) dir = DIR_PRESS;
        else if (y < regs.deflect_low && xc) dir = DIR_UP;
        else if (y > regs.deflect_high && xc) dir = DIR_DOWN;
        else if (x < regs.deflect_low && yc) dir = DIR_LEFT;
        else if (x > regs.deflect_high && yc) dir = DIR_RIGHT;
        else dir = DIR_NONE;
        res.sampled   = 1'b1;
        res.direction = dir;
        if (dir != last_dir) begin
          last_dir = dir;
          last_ms  = now;
          fire     = 1'b1;
        end else if ((dir == DIR_LEFT || dir == DIR_RIGHT) && elapsed >= regs.repeat_ms) begin
          last_ms = now;
          fire    = 1'b1;
        end
        if (fire && dir != DIR_NONE) begin
          res.action = 1'b1;
          if (dir == DIR_UP) begin
            mode       = ~mode;
            res.redraw = 1'b1;
          end else if (dir == DIR_LEFT && !mode) begin
            sum        = {1'b0, offset} + {{(OFS_W+1-STEP_W){1'b0}}, regs.offset_step};
            offset     = (sum > {1'b0, regs.offset_max}) ? regs.offset_max : sum[OFS_W-1:0];
            res.redraw = 1'b1;
          end else if (dir == DIR_RIGHT && !mode) begin
            offset     = (offset >= regs.offset_step) ? offset - regs.offset_step : '0;
            res.redraw = 1'b1;
          end
        end
      end
      res.view_mode   = mode;
      res.view_offset = offset;
      pending_results.push_back(res);
    endfunction

    task report(input string msg);
      mismatches++;
      if (mismatches <= 40) $display("mismatch: %s", msg);
    endtask

    task check_result(input result_t got);
      result_t want;
      if (pending_results.size() == 0) begin
        report("result item arrived with no sample pending");
        return;
      end
      want = pending_results.pop_front();
      if (got.sampled !== want.sampled)
        report($sformatf("sampled got %0d want %0d", got.sampled, want.sampled));
      if (got.direction !== want.direction)
        report($sformatf("direction got %0d want %0d", got.direction, want.direction));
      if (got.action !== want.action)
        report($sformatf("action got %0d want %0d", got.action, want.action));
      if (got.redraw !== want.redraw)
        report($sformatf("redraw got %0d want %0d", got.redraw, want.redraw));
      if (got.view_mode !== want.view_mode)
        report($sformatf("view_mode got %0d want %0d", got.view_mode, want.view_mode));
      if (got.view_offset !== want.view_offset)
        report($sformatf("view_offset got %0d want %0d", got.view_offset, want.view_offset));
    endtask
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_stall;
  logic [TIME_W-1:0]     in_now_ms;
  logic [ADC_BITS-1:0]   in_axis_x;
  logic [ADC_BITS-1:0]   in_axis_y;
  logic                  in_button_down;
  logic                  out_valid;
  logic                  out_stall;
  logic                  out_sampled;
  logic [DIR_W-1:0]      out_direction;
  logic                  out_action;
  logic                  out_redraw;
  logic                  out_view_mode;
  logic [OFS_W-1:0]      out_view_offset;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  direction_tracker tracker = new();
  int send_gap_max = 8;
  int take_gap_max = 8;
  int stall_burst  = 0;

  always #5 clk = ~clk;

  joystick_direction_qualifier u_top (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_now_ms       (in_now_ms),
    .in_axis_x       (in_axis_x),
    .in_axis_y       (in_axis_y),
    .in_button_down  (in_button_down),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_sampled     (out_sampled),
    .out_direction   (out_direction),
    .out_action      (out_action),
    .out_redraw      (out_redraw),
    .out_view_mode   (out_view_mode),
    .out_view_offset (out_view_offset),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  function automatic cfg_t draw_settings(input settings_kind_e kind);
    cfg_t         s;
    logic [127:0] raw;
    int           dl;
    int           cl;
    int           ch;
    case (kind)
      SET_ZERO: s = '0;
      SET_FULL: s = '1;
      SET_WILD: begin
        raw = {$urandom, $urandom, $urandom, $urandom};
        s   = raw[$bits(cfg_t)-1:0];
      end
      SET_SANE: begin
        dl = $urandom_range(1400, 1);
        cl = dl + $urandom_range(300, 0);
        ch = cl + $urandom_range(1500, 2);
        s.deflect_low  = ADC_BITS'(dl);
        s.center_low   = ADC_BITS'(cl);
        s.center_high  = ADC_BITS'(ch);
        s.deflect_high = ADC_BITS'(ch + $urandom_range(400, 0));
        s.quiet_ms     = MS_W'($urandom_range(100, 0));
        s.repeat_ms    = MS_W'($urandom_range(400, 0));
        s.offset_step  = STEP_W'($urandom);
        s.offset_max   = OFS_W'($urandom);
      end
      default: begin
        s.center_low   = RST_CENTER_LOW;
        s.center_high  = RST_CENTER_HIGH;
        s.deflect_low  = RST_DEFLECT_LOW;
        s.deflect_high = RST_DEFLECT_HIGH;
        s.quiet_ms     = RST_QUIET_MS;
        s.repeat_ms    = RST_REPEAT_MS;
        s.offset_step  = RST_OFFSET_STEP;
        s.offset_max   = RST_OFFSET_MAX;
      end
    endcase
    return s;
  endfunction

  function automatic logic [ADC_BITS-1:0] axis_in(input axis_zone_e zone);
    int cl;
    int ch;
    int dl;
    int dh;
    int v;
    cl = tracker.regs.center_low;
    ch = tracker.regs.center_high;
    dl = tracker.regs.deflect_low;
    dh = tracker.regs.deflect_high;
    case (zone)
      ZONE_CENTRE: v = (ch - cl >= 2) ? $urandom_range(ch - 1, cl + 1) : $urandom;
      ZONE_LOW:    v = (dl > 0) ? $urandom_range(dl - 1, 0) : 0;
      ZONE_HIGH:   v = (dh < AXIS_MAX) ? $urandom_range(AXIS_MAX, dh + 1) : AXIS_MAX;
      ZONE_EDGE: begin
        case ($urandom_range(3, 0))
          0: v = cl;
          1: v = ch;
          2: v = dl;
          default: v = dh;
        endcase
      end
      default: v = $urandom;
    endcase
    return ADC_BITS'(v);
  endfunction

  task automatic send_sample(input logic [TIME_W-1:0] now, input logic [ADC_BITS-1:0] x,
                             input logic [ADC_BITS-1:0] y, input logic btn);
    int gap;
    gap = $urandom_range(send_gap_max, 0);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_now_ms      <= now;
    in_axis_x      <= x;
    in_axis_y      <= y;
    in_button_down <= btn;
    do @(posedge clk); while (in_stall !== 1'b0);
    tracker.note_sample(now, x, y, btn);
  endtask

  task automatic wait_for_results();
    in_valid <= 1'b0;
    do @(negedge clk); while (tracker.pending_results.size() != 0);
    @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    tracker.set_reg(idx, data);
  endtask

  task automatic apply_settings(input cfg_t s);
    logic [CFG_DATA_W-1:0] noise;
    noise = CFG_DATA_W'($urandom);
    write_reg(REG_CENTER_LOW,   {noise[CFG_DATA_W-1:ADC_BITS], s.center_low});
    write_reg(REG_CENTER_HIGH,  {noise[CFG_DATA_W-1:ADC_BITS], s.center_high});
    write_reg(REG_DEFLECT_LOW,  {noise[CFG_DATA_W-1:ADC_BITS], s.deflect_low});
    write_reg(REG_DEFLECT_HIGH, {noise[CFG_DATA_W-1:ADC_BITS], s.deflect_high});
    write_reg(REG_QUIET_MS,     s.quiet_ms);
    write_reg(REG_REPEAT_MS,    s.repeat_ms);
    write_reg(REG_OFFSET_STEP,  {noise[CFG_DATA_W-1:STEP_W], s.offset_step});
    write_reg(REG_OFFSET_MAX,   {noise[CFG_DATA_W-1:OFS_W], s.offset_max});
    cfg_valid <= 1'b0;
  endtask

  initial begin : result_sink
    int      wait_left;
    result_t got;
    wait_left = 0;
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n === 1'b1 && out_valid === 1'b1 && !out_stall) begin
        got.sampled     = out_sampled;
        got.direction   = out_direction;
        got.action      = out_action;
        got.redraw      = out_redraw;
        got.view_mode   = out_view_mode;
        got.view_offset = out_view_offset;
        tracker.check_result(got);
        wait_left = $urandom_range(take_gap_max, 0);
      end else if (out_valid === 1'b1 && wait_left > 0) begin
        wait_left--;
      end
      if (stall_burst > 0) begin
        stall_burst--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= (wait_left > 0);
      end
    end
  end

  initial begin : stimulus
    settings_kind_e    plan [7];
    cfg_t              s;
    logic [TIME_W-1:0] clock_ms;
    logic [ADC_BITS-1:0] x;
    logic [ADC_BITS-1:0] y;
    logic              btn;
    logic [DIR_W-1:0]  hold_dir;
    int                hold_left;
    int                deb;
    int                rep;
    int                dt;
    plan = '{SET_SANE, SET_ZERO, SET_SANE, SET_FULL, SET_WILD, SET_SANE, SET_DEFAULT};
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_now_ms      = '0;
    in_axis_x      = '0;
    in_axis_y      = '0;
    in_button_down = 1'b0;
    cfg_valid      = 1'b0;
    cfg_index      = '0;
    cfg_data       = '0;
    hold_dir       = DIR_NONE;
    hold_left      = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Default thresholds: debounce, every direction, mode toggle, repeat and saturation at 0.
    send_sample(32'd10,  12'd2000, 12'd2000, 1'b0);
    send_sample(32'd50,  12'd0,    12'd0,    1'b1);
    send_sample(32'd60,  12'd4095, 12'd4095, 1'b1);
    send_sample(32'd100, 12'd2000, 12'd0,    1'b0);
    send_sample(32'd150, 12'd0,    12'd2000, 1'b0);
    send_sample(32'd200, 12'd2000, 12'd999,  1'b0);
    send_sample(32'd250, 12'd999,  12'd1501, 1'b0);
    send_sample(32'd399, 12'd0,    12'd2599, 1'b0);
    send_sample(32'd400, 12'd0,    12'd2000, 1'b0);
    send_sample(32'd450, 12'd4095, 12'd2000, 1'b0);
    send_sample(32'd600, 12'd3001, 12'd2000, 1'b0);
    send_sample(32'd750, 12'd4095, 12'd2000, 1'b0);
    send_sample(32'd800, 12'd2000, 12'd3001, 1'b0);
    send_sample(32'd850, 12'd2000, 12'd2000, 1'b0);
    send_sample(32'd900, 12'd1500, 12'd0,    1'b0);
    send_sample(32'd950, 12'd2600, 12'd3000, 1'b0);

    // No debounce, no repeat interval, largest step.
    wait_for_results();
    s = draw_settings(SET_DEFAULT);
    s.quiet_ms    = '0;
    s.repeat_ms   = '0;
    s.offset_step = '1;
    s.offset_max  = '1;
    apply_settings(s);
    send_sample(32'd1000, 12'd0, 12'd2000, 1'b0);
    send_sample(32'd1000, 12'd0, 12'd2000, 1'b0);

    // Offset above a lowered maximum, then the time stamp wrapping around.
    wait_for_results();
    s = draw_settings(SET_DEFAULT);
    s.offset_max = 12'd100;
    apply_settings(s);
    send_sample(32'd1200,       12'd0,    12'd2000, 1'b0);
    send_sample(32'hFFFF_FFF0,  12'd4095, 12'd2000, 1'b0);
    send_sample(32'h0000_0020,  12'd4095, 12'd2000, 1'b0);
    send_sample(32'h0000_0030,  12'd4095, 12'd2000, 1'b0);
    send_sample(32'h0000_0090,  12'd4095, 12'd2000, 1'b0);

    clock_ms = 32'h100;
    for (int ph = 0; ph < 7; ph++) begin
      wait_for_results();
      apply_settings(draw_settings(plan[ph]));
      for (int n = 0; n < 200; n++) begin
        if (n % 40 == 0) begin
          send_gap_max = ($urandom_range(2, 0) == 0) ? 0 : 8;
          take_gap_max = ($urandom_range(2, 0) == 0) ? 0 : 8;
        end
        if (ph == 2 && n == 60) begin
          in_valid <= 1'b0;
          @(negedge clk);
          send_gap_max = 0;
          stall_burst  = 80;
          @(posedge clk);
        end
        if (ph == 5 && n == 100) wait_for_results();
        deb = tracker.regs.quiet_ms;
        rep = tracker.regs.repeat_ms;
        if ($urandom_range(9, 0) == 0) begin
          clock_ms = $urandom_range(1, 0) ? $urandom : clock_ms + $urandom_range(100, 0);
          x   = ADC_BITS'($urandom);
          y   = ADC_BITS'($urandom);
          btn = 1'($urandom);
        end else begin
          if (hold_left == 0) begin
            case ($urandom_range(9, 0))
              0: hold_dir = DIR_NONE;
              1: hold_dir = DIR_PRESS;
              2: hold_dir = DIR_UP;
              3: hold_dir = DIR_DOWN;
              4, 5, 6: hold_dir = DIR_LEFT;
              default: hold_dir = DIR_RIGHT;
            endcase
            hold_left = $urandom_range(8, 1);
          end
          hold_left--;
          case ($urandom_range(4, 0))
            0: dt = (deb > 0) ? $urandom_range(deb - 1, 0) : 0;
            1: dt = deb + $urandom_range(3, 0);
            2: dt = $urandom_range(2 * rep + 2, 0);
            3: dt = rep + $urandom_range(2, 0);
            default: dt = $urandom_range(2000, 0);
          endcase
          clock_ms = clock_ms + dt;
          x   = axis_in(ZONE_ANY);
          y   = axis_in(ZONE_ANY);
          btn = 1'b0;
          case (hold_dir)
            DIR_PRESS: btn = 1'b1;
            DIR_UP: begin
              x = axis_in(ZONE_CENTRE);
              y = axis_in(ZONE_LOW);
            end
            DIR_DOWN: begin
              x = axis_in(ZONE_CENTRE);
              y = axis_in(ZONE_HIGH);
            end
            DIR_LEFT: begin
              x = axis_in(ZONE_LOW);
              y = axis_in(ZONE_CENTRE);
            end
            DIR_RIGHT: begin
              x = axis_in(ZONE_HIGH);
              y = axis_in(ZONE_CENTRE);
            end
            default: begin
              if ($urandom_range(1, 0) == 0) begin
                x = axis_in(ZONE_CENTRE);
                y = axis_in(ZONE_CENTRE);
              end
            end
          endcase
          if ($urandom_range(9, 0) == 0) begin
            if ($urandom_range(1, 0) == 0) x = axis_in(ZONE_EDGE);
            else y = axis_in(ZONE_EDGE);
          end
        end
        send_sample(clock_ms, x, y, btn);
      end
    end

    wait_for_results();
    repeat (8) @(posedge clk);
    if (tracker.mismatches == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end

  initial begin : watchdog
    #3000000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

@@ files.f @@
hdl/jdq_pkg.sv
hdl/jdq_classify.sv
hdl/jdq_event.sv
hdl/joystick_direction_qualifier.sv
dv/tb.sv
